[src/cghlt_pkg.sv]
// ----------------------------------------------------------------------------
// cghlt_pkg
// Shared types, byte constants and tag codes for the CGI header tokenizer.
// ----------------------------------------------------------------------------
package cghlt_pkg;

  // Characters of the header grammar
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_DASH    = 8'h2D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] PRINT_LOW    = 8'd32;
  localparam logic [7:0] PRINT_HIGH   = 8'd126;

  // Byte tags
  localparam logic [2:0] KIND_FRAME   = 3'd0;
  localparam logic [2:0] KIND_KEY     = 3'd1;
  localparam logic [2:0] KIND_VALUE   = 3'd2;
  localparam logic [2:0] KIND_DONE    = 3'd3;
  localparam logic [2:0] KIND_BODY    = 3'd4;
  localparam logic [2:0] KIND_DROP    = 3'd5;

  // Response status
  localparam logic [1:0] ST_HEADERS   = 2'd0;
  localparam logic [1:0] ST_FINISHED  = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_EOF       = 2'd3;

  // One byte of the response stream
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_flag;
    logic       last_flag;
  } byte_t;

  // One tagged byte
  typedef struct packed {
    logic [2:0] byte_kind;
    logic [7:0] byte_echo;
    logic [1:0] parse_status;
  } tag_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_printable(input logic [7:0] c);
    return (c >= PRINT_LOW) && (c <= PRINT_HIGH);
  endfunction

endpackage

[src/cghlt_fsm.sv]
// ----------------------------------------------------------------------------
// cghlt_fsm
// Header grammar state machine: tags the offered byte and advances the
// parse phase on each transfer.
// ----------------------------------------------------------------------------
module cghlt_fsm import cghlt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  byte_t item,
  output tag_t  result
);

  typedef enum logic [2:0] {
    PH_LINE_START   = 3'd0,
    PH_KEY          = 3'd1,
    PH_BEFORE_VALUE = 3'd2,
    PH_VALUE        = 3'd3,
    PH_HDR_CR       = 3'd4,
    PH_END_CR       = 3'd5,
    PH_BODY         = 3'd6,
    PH_BAD          = 3'd7
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  phase_t     cur;
  logic [7:0] c;
  logic [2:0] kind;
  logic [1:0] status;

  assign c = item.data_byte;

  // Classify the byte against the current phase
  always_comb begin
    cur        = item.first_flag ? PH_LINE_START : phase;
    kind       = KIND_DROP;
    status     = ST_MALFORMED;
    phase_next = PH_BAD;
    unique case (cur)
      PH_LINE_START: begin
        if (c == CHAR_CR) begin
          kind = KIND_FRAME; status = ST_HEADERS; phase_next = PH_END_CR;
        end else if (is_alnum(c)) begin
          kind = KIND_KEY; status = ST_HEADERS; phase_next = PH_KEY;
        end
      end
      PH_KEY: begin
        if (c == CHAR_COLON) begin
          kind = KIND_FRAME; status = ST_HEADERS; phase_next = PH_BEFORE_VALUE;
        end else if (is_alnum(c) || (c == CHAR_DASH)) begin
          kind = KIND_KEY; status = ST_HEADERS; phase_next = PH_KEY;
        end
      end
      PH_BEFORE_VALUE, PH_VALUE: begin
        if ((c == CHAR_SPACE) && (cur == PH_BEFORE_VALUE)) begin
          kind = KIND_FRAME; status = ST_HEADERS; phase_next = PH_BEFORE_VALUE;
        end else if (c == CHAR_CR) begin
          kind = KIND_FRAME; status = ST_HEADERS; phase_next = PH_HDR_CR;
        end else if (is_printable(c)) begin
          kind = KIND_VALUE; status = ST_HEADERS; phase_next = PH_VALUE;
        end
      end
      PH_HDR_CR: begin
        if (c == CHAR_LF) begin
          kind = KIND_DONE; status = ST_HEADERS; phase_next = PH_LINE_START;
        end
      end
      PH_END_CR: begin
        if (c == CHAR_LF) begin
          kind = KIND_FRAME; status = ST_FINISHED; phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        kind = KIND_BODY; status = ST_FINISHED; phase_next = PH_BODY;
      end
      PH_BAD: begin
        kind = KIND_DROP; status = ST_MALFORMED; phase_next = PH_BAD;
      end
      default: begin
        kind = KIND_DROP; status = ST_MALFORMED; phase_next = PH_BAD;
      end
    endcase

    // End of response: flag open headers and restart at line start
    if (item.last_flag) begin
      if (status == ST_HEADERS) begin
        status = ST_EOF;
      end
      phase_next = PH_LINE_START;
    end
  end

  assign result.byte_kind    = kind;
  assign result.byte_echo    = c;
  assign result.parse_status = status;

  // Hold the phase between transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LINE_START;
    end else if (advance) begin
      phase <= phase_next;
    end
  end

endmodule

[src/cgi_header_line_tokenizer.sv]
// ----------------------------------------------------------------------------
// cgi_header_line_tokenizer
// Tags each byte of a CGI response as key, value, framing, header complete,
// body or discarded, and reports the header status alongside.
// ----------------------------------------------------------------------------
//
//   channel   handshake                payload
//   -------   ----------------------   -------------------------------------
//   byte      byte_valid / byte_stall  byte_item: data_byte, first/last_flag
//   tag       tag_valid  / tag_stall   tag_item:  byte_kind, byte_echo, status
//
// One byte per cycle while no tag is stalled; each byte is tagged in the cycle
// it is taken and its tag appears on the next cycle from the output register.
// The phase register loops back through the grammar logic.
// Reset returns the parser to line start and empties the output register.
// A stalled tag holds the output register; a new byte is taken in the same
// cycle that the waiting tag is transferred.
module cgi_header_line_tokenizer import cghlt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  byte_valid,
  output logic  byte_stall,
  input  byte_t byte_item,
  output logic  tag_valid,
  input  logic  tag_stall,
  output tag_t  tag_item
);

  logic take;
  tag_t tag_comb;

  // Take a byte whenever the output register is free or draining
  assign byte_stall = tag_valid && tag_stall;
  assign take       = byte_valid && !byte_stall;

  cghlt_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .advance (take),
    .item    (byte_item),
    .result  (tag_comb)
  );

  // Output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
    end else if (take) begin
      tag_valid <= 1'b1;
    end else if (!tag_stall) begin
      tag_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (take) begin
      tag_item <= tag_comb;
    end
  end

  // Every taken byte leaves a tag in the output register
  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    take |=> tag_valid)
    else $error("taken byte produced no tag");

  // Malformed status and discard tag go together
  a_bad_drop: assert property (@(posedge clk) disable iff (rst)
    tag_valid |-> ((tag_item.parse_status == ST_MALFORMED) ==
                   (tag_item.byte_kind == KIND_DROP)))
    else $error("malformed status without discard tag");

  // Body bytes only after the headers have finished
  a_body_done: assert property (@(posedge clk) disable iff (rst)
    (tag_valid && (tag_item.byte_kind == KIND_BODY)) |->
      (tag_item.parse_status == ST_FINISHED))
    else $error("body byte outside finished headers");

  // A completed header line never reports finished headers
  a_done_open: assert property (@(posedge clk) disable iff (rst)
    (tag_valid && (tag_item.byte_kind == KIND_DONE)) |->
      ((tag_item.parse_status == ST_HEADERS) || (tag_item.parse_status == ST_EOF)))
    else $error("header complete with wrong status");

endmodule
